// ----- rtl/core/sbp_pkg.sv -----
package sbp_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int PHASE_FRAC_BITS = 13;
    localparam int PHASE_WIDTH     = PHASE_FRAC_BITS + 3;
    localparam int THRESH_WIDTH    = 8;

    // angle arithmetic in Q.30 radians, rounded once at the end
    localparam int ANGLE_BITS  = 30;
    localparam int ANGLE_WIDTH = ANGLE_BITS + 4;
    localparam int DROP_BITS   = ANGLE_BITS - PHASE_FRAC_BITS;

    // normalised operands have their leading one at bit NORM_BIT
    localparam int NORM_BIT    = 40;
    localparam int NORM_WIDTH  = NORM_BIT + 1;
    localparam int NORM_STEPS  = $clog2(NORM_WIDTH);
    localparam int XY_WIDTH    = NORM_WIDTH + 3;
    localparam int TABLE_LEN   = 24;

    // squaring, summing, one stage per root bit, rounding
    localparam int MAG_LAT     = SAMPLE_WIDTH + 3;

    localparam longint PI_Q30_VAL      = 64'sd3373259426;
    localparam longint HALF_PI_Q30_VAL = 64'sd1686629713;

    localparam logic signed [ANGLE_WIDTH-1:0] PI_Q30      = ANGLE_WIDTH'(PI_Q30_VAL);
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q30 = ANGLE_WIDTH'(HALF_PI_Q30_VAL);
    localparam logic signed [PHASE_WIDTH-1:0] PHASE_PI    =
        PHASE_WIDTH'((PI_Q30_VAL + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] real_part;
        logic signed [SAMPLE_WIDTH-1:0] imag_part;
        logic                           last_bin;
    } bin_item_t;

    typedef struct packed {
        logic        [SAMPLE_WIDTH-1:0] magnitude;
        logic signed [PHASE_WIDTH-1:0]  phase;
        logic                           last_out;
    } polar_item_t;

    typedef enum logic [1:0] {
        PH_ROTATE,
        PH_ZERO,
        PH_POS_HALF,
        PH_NEG_HALF
    } phase_class_t;

    typedef struct packed {
        phase_class_t cls;
        logic         re_neg;
        logic         im_neg;
    } phase_side_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [31:0] atan_entry(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'h3243F6A8;
            1:       val = 32'h1DAC6705;
            2:       val = 32'h0FADBAFC;
            3:       val = 32'h07F56EA6;
            4:       val = 32'h03FEAB76;
            5:       val = 32'h01FFD55B;
            6:       val = 32'h00FFFAAA;
            7:       val = 32'h007FFF55;
            8:       val = 32'h003FFFEA;
            9:       val = 32'h001FFFFD;
            10:      val = 32'h000FFFFF;
            11:      val = 32'h0007FFFF;
            12:      val = 32'h0003FFFF;
            13:      val = 32'h0001FFFF;
            14:      val = 32'h0000FFFF;
            15:      val = 32'h00007FFF;
            16:      val = 32'h00003FFF;
            17:      val = 32'h00001FFF;
            18:      val = 32'h00000FFF;
            19:      val = 32'h000007FF;
            20:      val = 32'h000003FF;
            21:      val = 32'h000001FF;
            22:      val = 32'h000000FF;
            23:      val = 32'h0000007F;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/sbp_delay.sv -----
module sbp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    if (DEPTH == 0) begin : g_none
        assign q = d;
    end else begin : g_line
        logic [WIDTH-1:0] line_reg [0:DEPTH-1];

        always_ff @(posedge clk)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end

        assign q = line_reg[DEPTH-1];
    end

endmodule

// ----- rtl/core/sbp_mag.sv -----
module sbp_mag (
    input  logic                             clk,
    input  logic [sbp_pkg::SAMPLE_WIDTH-1:0] abs_re,
    input  logic [sbp_pkg::SAMPLE_WIDTH-1:0] abs_im,
    output logic [sbp_pkg::SAMPLE_WIDTH-1:0] magnitude
);
    import sbp_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int RW = 2 * SW;
    localparam int MW = SW + 2;

    logic [RW-1:0] sq_re_reg;
    logic [RW-1:0] sq_im_reg;
    logic [RW-1:0] rad_reg  [0:SW-1];
    logic [SW-1:0] root_reg [0:SW];
    logic [MW-1:0] rem_reg  [0:SW];
    logic [SW-1:0] root_next [0:SW-1];
    logic [MW-1:0] rem_next  [0:SW-1];
    logic [SW:0]   mag_sum;
    logic [SW-1:0] mag_reg;

    always_ff @(posedge clk)
    begin
        sq_re_reg   <= RW'(abs_re) * RW'(abs_re);
        sq_im_reg   <= RW'(abs_im) * RW'(abs_im);
        rad_reg[0]  <= sq_re_reg + sq_im_reg;
        root_reg[0] <= '0;
        rem_reg[0]  <= '0;
    end

    // one root bit per stage, radicand consumed two bits at a time
    for (genvar i = 0; i < SW; i++) begin : g_root
        logic [MW-1:0] rem_sh;
        logic [MW-1:0] trial;
        logic [MW:0]   diff;

        always_comb
        begin
            rem_sh       = {rem_reg[i][SW-1:0], rad_reg[i][RW-1 -: 2]};
            trial        = {root_reg[i], 2'b01};
            diff         = {1'b0, rem_sh} - {1'b0, trial};
            root_next[i] = {root_reg[i][SW-2:0], ~diff[MW]};
            rem_next[i]  = diff[MW] ? rem_sh : diff[MW-1:0];
        end

        always_ff @(posedge clk)
        begin
            root_reg[i+1] <= root_next[i];
            rem_reg[i+1]  <= rem_next[i];
        end

        if (i < SW - 1) begin : g_shift
            always_ff @(posedge clk)
            begin
                rad_reg[i+1] <= {rad_reg[i][RW-3:0], 2'b00};
            end
        end
    end

    // round up when the remainder exceeds the floor root
    assign mag_sum = {1'b0, root_reg[SW]}
                   + {{SW{1'b0}}, (rem_reg[SW] > {2'b00, root_reg[SW]})};

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_sum[SW] ? {SW{1'b1}} : mag_sum[SW-1:0];
    end

    assign magnitude = mag_reg;

endmodule

// ----- rtl/core/sbp_phase.sv -----
module sbp_phase #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic                                   clk,
    input  logic        [sbp_pkg::THRESH_WIDTH-1:0] threshold,
    input  logic        [sbp_pkg::SAMPLE_WIDTH-1:0] abs_re,
    input  logic        [sbp_pkg::SAMPLE_WIDTH-1:0] abs_im,
    input  logic                                   re_neg,
    input  logic                                   im_neg,
    output logic signed [sbp_pkg::PHASE_WIDTH-1:0]  phase
);
    import sbp_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = NORM_WIDTH;
    localparam int NS = NORM_STEPS;
    localparam int XW = XY_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int RS = ROTATION_STAGES;

    phase_side_t               side_next;
    phase_side_t               side_reg [0:NS+RS];
    logic        [NW-1:0]      nx_reg   [0:NS];
    logic        [NW-1:0]      ny_reg   [0:NS];
    logic signed [XW-1:0]      x_reg    [1:RS-1];
    logic signed [XW-1:0]      y_reg    [1:RS-1];
    logic signed [AW-1:0]      z_reg    [1:RS];
    logic signed [AW-1:0]      t_clamp;
    logic signed [AW-1:0]      ph_next;
    logic signed [AW-1:0]      ph_reg;
    logic signed [AW-1:0]      ph_round;
    logic signed [PHASE_WIDTH-1:0] phase_reg;

    // classify against the zero threshold
    always_comb
    begin
        side_next.re_neg = re_neg;
        side_next.im_neg = im_neg;
        if (abs_re > SW'(threshold))
            side_next.cls = PH_ROTATE;
        else if (abs_im <= SW'(threshold))
            side_next.cls = PH_ZERO;
        else if (im_neg)
            side_next.cls = PH_NEG_HALF;
        else
            side_next.cls = PH_POS_HALF;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        nx_reg[0]   <= NW'(abs_re);
        ny_reg[0]   <= NW'(abs_im);
    end

    for (genvar k = 0; k < NS + RS; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_reg[k];
        end
    end

    // shift both operands left until the larger has its top bit set
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - j);
        logic [NW-1:0] m;

        assign m = nx_reg[j] | ny_reg[j];

        always_ff @(posedge clk)
        begin
            if (m[NW-1 -: SH] == '0)
            begin
                nx_reg[j+1] <= nx_reg[j] << SH;
                ny_reg[j+1] <= ny_reg[j] << SH;
            end
            else
            begin
                nx_reg[j+1] <= nx_reg[j];
                ny_reg[j+1] <= ny_reg[j];
            end
        end
    end

    // vectoring rotations, driving y towards zero
    for (genvar i = 0; i < RS; i++) begin : g_rot
        localparam logic signed [AW-1:0] AT = AW'(atan_entry(i));
        logic signed [XW-1:0] xc;
        logic signed [XW-1:0] yc;
        logic signed [AW-1:0] zc;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [AW-1:0] z_next;

        if (i == 0) begin : g_head
            assign xc = $signed({3'b000, nx_reg[NS]});
            assign yc = $signed({3'b000, ny_reg[NS]});
            assign zc = '0;
        end else begin : g_body
            assign xc = x_reg[i];
            assign yc = y_reg[i];
            assign zc = z_reg[i];
        end

        always_comb
        begin
            xs = xc >>> i;
            ys = yc >>> i;
            if (!yc[XW-1])
            begin
                x_next = xc + ys;
                y_next = yc - xs;
                z_next = zc + AT;
            end
            else
            begin
                x_next = xc - ys;
                y_next = yc + xs;
                z_next = zc - AT;
            end
        end

        always_ff @(posedge clk)
        begin
            z_reg[i+1] <= z_next;
        end

        if (i < RS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
            end
        end
    end

    // clamp to the first quadrant, then map to the item's quadrant
    always_comb
    begin
        t_clamp = z_reg[RS];
        if (t_clamp[AW-1])
            t_clamp = '0;
        else if (t_clamp > HALF_PI_Q30)
            t_clamp = HALF_PI_Q30;

        case (side_reg[NS+RS].cls)
            PH_ZERO:     ph_next = '0;
            PH_POS_HALF: ph_next = HALF_PI_Q30;
            PH_NEG_HALF: ph_next = -HALF_PI_Q30;
            PH_ROTATE:
            begin
                if (!side_reg[NS+RS].re_neg)
                    ph_next = side_reg[NS+RS].im_neg ? -t_clamp : t_clamp;
                else
                    ph_next = side_reg[NS+RS].im_neg ? (t_clamp - PI_Q30)
                                                     : (PI_Q30 - t_clamp);
            end
            default:     ph_next = '0;
        endcase
    end

    assign ph_round = ph_reg + AW'(1 << (DROP_BITS - 1));

    always_ff @(posedge clk)
    begin
        ph_reg    <= ph_next;
        phase_reg <= PHASE_WIDTH'(ph_round >>> DROP_BITS);
    end

    assign phase = phase_reg;

endmodule

// ----- rtl/core/spectrum_bin_to_polar.sv -----
// Channel   Ports                          Handshake
// ------    -----------------------------  ------------------------------------
// bin in    start, busy, bin               taken when start is high, busy low
// result    done, result                   one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready
//
// A bin may be started every cycle; busy stays low and cfg_ready stays high.
// Results leave after the longer of the one-bit-per-stage square root and the
// normalise-plus-rotation phase path; the shorter path is delayed to match.
// rst_n clears the item valid line and the threshold; data stages are not reset.
module spectrum_bin_to_polar #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  sbp_pkg::bin_item_t                 bin,
    output logic                               done,
    output sbp_pkg::polar_item_t               result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbp_pkg::THRESH_WIDTH-1:0]   cfg_data
);
    import sbp_pkg::*;

    localparam int SW        = SAMPLE_WIDTH;
    localparam int PHASE_LAT = NORM_STEPS + ROTATION_STAGES + 3;
    localparam int LAT       = (MAG_LAT > PHASE_LAT) ? MAG_LAT : PHASE_LAT;
    localparam int OUT_LAT   = LAT + 1;

    logic                         accept;
    logic [THRESH_WIDTH-1:0]      threshold_reg;
    logic [LAT:0]                 valid_reg;
    logic [LAT:0]                 last_reg;
    logic [SW-1:0]                abs_re_next;
    logic [SW-1:0]                abs_im_next;
    logic [SW-1:0]                abs_re_reg;
    logic [SW-1:0]                abs_im_reg;
    logic                         re_neg_reg;
    logic                         im_neg_reg;
    logic [SW-1:0]                mag_raw;
    logic [SW-1:0]                mag_out;
    logic signed [PHASE_WIDTH-1:0] phase_raw;
    logic [PHASE_WIDTH-1:0]       phase_out;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= '0;
        else if (cfg_valid && cfg_ready)
            threshold_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-1:0], accept};
    end

    always_comb
    begin
        abs_re_next = bin.real_part[SW-1] ? SW'(-bin.real_part) : SW'(bin.real_part);
        abs_im_next = bin.imag_part[SW-1] ? SW'(-bin.imag_part) : SW'(bin.imag_part);
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= {last_reg[LAT-1:0], bin.last_bin};
        abs_re_reg <= abs_re_next;
        abs_im_reg <= abs_im_next;
        re_neg_reg <= bin.real_part[SW-1];
        im_neg_reg <= bin.imag_part[SW-1];
    end

    sbp_mag u_mag (
        .clk       (clk),
        .abs_re    (abs_re_reg),
        .abs_im    (abs_im_reg),
        .magnitude (mag_raw)
    );

    sbp_phase #(
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_phase (
        .clk       (clk),
        .threshold (threshold_reg),
        .abs_re    (abs_re_reg),
        .abs_im    (abs_im_reg),
        .re_neg    (re_neg_reg),
        .im_neg    (im_neg_reg),
        .phase     (phase_raw)
    );

    // align the two paths
    sbp_delay #(
        .WIDTH (SW),
        .DEPTH (LAT - MAG_LAT)
    ) u_mag_align (
        .clk (clk),
        .d   (mag_raw),
        .q   (mag_out)
    );

    sbp_delay #(
        .WIDTH (PHASE_WIDTH),
        .DEPTH (LAT - PHASE_LAT)
    ) u_phase_align (
        .clk (clk),
        .d   (phase_raw),
        .q   (phase_out)
    );

    assign done = valid_reg[LAT];

    always_comb
    begin
        result.magnitude = mag_out;
        result.phase     = $signed(phase_out);
        result.last_out  = last_reg[LAT];
    end

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##OUT_LAT done)
        else $error("item result missing at fixed latency");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.phase <= PHASE_PI) && (result.phase >= -PHASE_PI))
        else $error("phase outside -pi..pi");

    a_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.magnitude == '0)) |-> (result.phase == '0))
        else $error("zero bin with non-zero phase");

endmodule
